/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/slbp_pkg.sv */
// types, codes and color tables for the status led breathing block
package slbp_pkg;

    typedef enum logic [1:0] {
        FUNC_SET_MODE = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_OFF      = 2'd2,
        FUNC_RSVD     = 2'd3
    } func_t;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_LEADER  = 3'd1;
    localparam logic [2:0] MODE_MEMBER  = 3'd2;
    localparam logic [2:0] MODE_RELAY   = 3'd3;
    localparam logic [2:0] MODE_CHILD   = 3'd4;
    localparam logic [2:0] MODE_JOINING = 3'd5;
    localparam logic [2:0] MODE_LOST    = 3'd6;

    localparam logic CFG_LED_ENABLE    = 1'b0;
    localparam logic CFG_TICK_INTERVAL = 1'b1;

    localparam logic [15:0] TICK_INTERVAL_RST = 16'd120;
    localparam logic [7:0]  MAX_LEVEL         = 8'd10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic logic [3:0] idle_step(input logic [2:0] phase);
        logic [3:0] s;
        case (phase)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd1;
            3'd2:    s = 4'd2;
            3'd3:    s = 4'd3;
            3'd4:    s = 4'd4;
            3'd5:    s = 4'd3;
            3'd6:    s = 4'd2;
            default: s = 4'd1;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] normal_step(input logic [2:0] phase);
        logic [3:0] s;
        case (phase)
            3'd0:    s = 4'd1;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd3;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd6;
            3'd5:    s = 4'd5;
            3'd6:    s = 4'd3;
            default: s = 4'd2;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] alert_step(input logic [2:0] phase);
        logic [3:0] s;
        case (phase)
            3'd0:    s = 4'd2;
            3'd1:    s = 4'd4;
            3'd2:    s = 4'd6;
            3'd3:    s = 4'd8;
            3'd4:    s = 4'd10;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd6;
            default: s = 4'd4;
        endcase
        return s;
    endfunction

    // (base * step + 127) / 255, divide by 255 as (x + (x >> 8) + 1) >> 8
    function automatic logic [7:0] scale_channel(input logic [7:0] base,
                                                 input logic [3:0] step);
        logic [12:0] prod;
        logic [12:0] sum;
        logic [12:0] quo;
        prod = 13'(base) * 13'(step);
        sum  = prod + 13'd127;
        quo  = (sum + (sum >> 8) + 13'd1) >> 8;
        return quo[7:0];
    endfunction

    function automatic rgb_t mode_color(input logic [2:0] mode, input logic [2:0] phase);
        rgb_t       base;
        logic [3:0] step;
        rgb_t       c;
        case (mode)
            MODE_LEADER: begin
                base = '{8'd255, 8'd96, 8'd0};
                step = normal_step(phase);
            end
            MODE_MEMBER, MODE_CHILD: begin
                base = '{8'd0, 8'd96, 8'd255};
                step = normal_step(phase);
            end
            MODE_RELAY: begin
                base = '{8'd160, 8'd0, 8'd255};
                step = normal_step(phase);
            end
            MODE_JOINING: begin
                base = '{8'd255, 8'd160, 8'd0};
                step = alert_step(phase);
            end
            MODE_LOST: begin
                base = '{8'd255, 8'd0, 8'd0};
                step = alert_step(phase);
            end
            default: begin
                base = '{8'd255, 8'd255, 8'd255};
                step = idle_step(phase);
            end
        endcase
        c.red   = scale_channel(base.red, step);
        c.green = scale_channel(base.green, step);
        c.blue  = scale_channel(base.blue, step);
        return c;
    endfunction

endpackage

/* hdl/status_led_breathing_pattern.sv */
// status led breathing pattern: request register, mode/phase state and color result register
// an accepted request waits in the input register, then its color is registered for m_valid
// throughput: one request per cycle unless the result stalls, set by the single input
// register and the single result register; a request that yields no color still takes one slot
// reset (aresetn low, synchronous): led disabled, interval 120 ms, mode idle and not applied,
// phase 0, last tick time 0, both stages empty
module status_led_breathing_pattern (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);
    import slbp_pkg::*;

    logic        led_enable_reg, led_enable_next;
    logic [15:0] interval_reg, interval_next;
    logic [2:0]  cur_mode_reg, cur_mode_next;
    logic        applied_reg, applied_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] last_tick_reg, last_tick_next;

    logic        in_valid_reg, in_valid_next;
    func_t       in_func_reg;
    logic [2:0]  in_mode_reg;
    logic [31:0] in_now_reg;

    logic        out_valid_reg, out_valid_next;
    rgb_t        out_color_reg, out_color_next;

    logic        advance;
    logic        emit;
    logic        black;
    logic [31:0] delta;
    rgb_t        color;

    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;

        led_enable_next = led_enable_reg;
        interval_next   = interval_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LED_ENABLE:    led_enable_next = cfg_wdata[0];
                CFG_TICK_INTERVAL: interval_next   = cfg_wdata;
                default:           led_enable_next = led_enable_reg;
            endcase
        end

        cur_mode_next  = cur_mode_reg;
        applied_next   = applied_reg;
        phase_next     = phase_reg;
        last_tick_next = last_tick_reg;
        emit           = 1'b0;
        black          = 1'b0;
        delta          = in_now_reg - last_tick_reg;

        if (advance) begin
            case (in_func_reg)
                FUNC_SET_MODE: begin
                    if (!(applied_reg && cur_mode_reg == in_mode_reg)) begin
                        cur_mode_next = in_mode_reg;
                        applied_next  = 1'b1;
                        phase_next    = 3'd0;
                        emit          = led_enable_reg;
                    end
                end
                FUNC_TICK: begin
                    if (led_enable_reg && !(delta < {16'd0, interval_reg})) begin
                        last_tick_next = in_now_reg;
                        phase_next     = phase_reg + 3'd1;
                        emit           = 1'b1;
                    end
                end
                FUNC_OFF: begin
                    emit  = led_enable_reg;
                    black = 1'b1;
                end
                default: emit = 1'b0;
            endcase
        end

        color = mode_color(cur_mode_next, phase_next);

        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_color_next = out_color_reg;
        if (advance) begin
            out_valid_next = emit;
            if (emit) begin
                out_color_next = black ? '0 : color;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_enable_reg <= 1'b0;
            interval_reg   <= TICK_INTERVAL_RST;
            cur_mode_reg   <= MODE_IDLE;
            applied_reg    <= 1'b0;
            phase_reg      <= 3'd0;
            last_tick_reg  <= 32'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            led_enable_reg <= led_enable_next;
            interval_reg   <= interval_next;
            cur_mode_reg   <= cur_mode_next;
            applied_reg    <= applied_next;
            phase_reg      <= phase_next;
            last_tick_reg  <= last_tick_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= func_t'(s_func);
            in_mode_reg <= s_mode;
            in_now_reg  <= s_now_ms;
        end
        out_color_reg <= out_color_next;
    end

    assign m_valid = out_valid_reg;
    assign m_red   = out_color_reg.red;
    assign m_green = out_color_reg.green;
    assign m_blue  = out_color_reg.blue;

endmodule

/* hdl/slbp_checker.sv */
// port-level checker for the status led breathing block, bound to the top level
`include "assert_macros.svh"

module slbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_red,
    input logic [7:0]  m_green,
    input logic [7:0]  m_blue
);
    import slbp_pkg::*;

    // reset empties the result stage
    `ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

    // input side only stalls behind a stalled result
    `ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // a stalled result keeps its color
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_red) && $stable(m_green) && $stable(m_blue))

    // largest table step keeps every channel at or below the peak level
    `ASSERT_IMPLY(a_level_range, aclk, aresetn, m_valid,
        m_red <= MAX_LEVEL && m_green <= MAX_LEVEL && m_blue <= MAX_LEVEL)

endmodule

bind status_led_breathing_pattern slbp_checker u_slbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_red   (m_red),
    .m_green (m_green),
    .m_blue  (m_blue)
);

/* tb/sv/status_led_breathing_pattern_tb.sv */
// testbench for the status led breathing pattern block: directed table, random requests, color predictor
module status_led_breathing_pattern_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slbp_pkg::*;

    localparam logic [2:0]  MODE_SPARE   = 3'd7;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_ITEMS = 1700;
    // step tables, phase 0 in the low nibble
    localparam logic [31:0] IDLE_STEPS   = {4'd1, 4'd2, 4'd3, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam logic [31:0] NORMAL_STEPS = {4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd3, 4'd2, 4'd1};
    localparam logic [31:0] ALERT_STEPS  = {4'd4, 4'd6, 4'd8, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2};

    typedef struct packed {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        logic [1:0]  func;
        logic [2:0]  mode;
        logic [31:0] now;
        bit          typed;
        bit          yields;
        rgb_t        color;
    } plan_row_t;

    bit          aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [2:0]  s_mode;
    logic [31:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;

    // predictor state and register copies
    bit          led_on;
    logic [15:0] interval_ms;
    logic [2:0]  cur_mode;
    bit          mode_set;
    logic [2:0]  breath_phase;
    logic [31:0] tick_stamp;

    rgb_t        pending_colors[$];
    plan_row_t   directed_plan[$];
    int          errors;
    int          quiet_cycles;
    bit          cur_typed;
    bit          cur_yields;
    rgb_t        cur_color;
    bit          tx_idles;
    bit          rx_idles;
    bit          hold_rx;

    status_led_breathing_pattern DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_mode    (s_mode),
        .s_now_ms  (s_now_ms),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic rgb_t breathe_color(input logic [2:0] m, input logic [2:0] ph);
        int unsigned r, g, b, s;
        rgb_t        c;
        case (m)
            MODE_LEADER: begin
                r = 255; g = 96; b = 0;
                s = 32'(NORMAL_STEPS[{ph, 2'b00} +: 4]);
            end
            MODE_MEMBER, MODE_CHILD: begin
                r = 0; g = 96; b = 255;
                s = 32'(NORMAL_STEPS[{ph, 2'b00} +: 4]);
            end
            MODE_RELAY: begin
                r = 160; g = 0; b = 255;
                s = 32'(NORMAL_STEPS[{ph, 2'b00} +: 4]);
            end
            MODE_JOINING: begin
                r = 255; g = 160; b = 0;
                s = 32'(ALERT_STEPS[{ph, 2'b00} +: 4]);
            end
            MODE_LOST: begin
                r = 255; g = 0; b = 0;
                s = 32'(ALERT_STEPS[{ph, 2'b00} +: 4]);
            end
            default: begin
                r = 255; g = 255; b = 255;
                s = 32'(IDLE_STEPS[{ph, 2'b00} +: 4]);
            end
        endcase
        c.red   = 8'((r * s + 127) / 255);
        c.green = 8'((g * s + 127) / 255);
        c.blue  = 8'((b * s + 127) / 255);
        return c;
    endfunction

    function automatic bit next_color(input logic [1:0] f, input logic [2:0] m,
                                      input logic [31:0] now, output rgb_t c);
        logic [31:0] elapsed;
        c = '0;
        case (f)
            FUNC_SET_MODE: begin
                if (mode_set && cur_mode == m) begin
                    return 1'b0;
                end
                cur_mode     = m;
                mode_set     = 1'b1;
                breath_phase = 3'd0;
                if (!led_on) begin
                    return 1'b0;
                end
                c = breathe_color(cur_mode, breath_phase);
                return 1'b1;
            end
            FUNC_TICK: begin
                elapsed = now - tick_stamp;
                if (!led_on || elapsed < {16'd0, interval_ms}) begin
                    return 1'b0;
                end
                tick_stamp   = now;
                breath_phase = breath_phase + 3'd1;
                c = breathe_color(cur_mode, breath_phase);
                return 1'b1;
            end
            FUNC_OFF: begin
                return led_on;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic plan_row_t req_row(input logic [1:0] f, input logic [2:0] m,
                                          input logic [31:0] now);
        plan_row_t row;
        row      = '0;
        row.func = f;
        row.mode = m;
        row.now  = now;
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic [1:0] f, input logic [2:0] m,
                                            input logic [31:0] now, input bit yields,
                                            input rgb_t color);
        plan_row_t row;
        row        = req_row(f, m, now);
        row.typed  = 1'b1;
        row.yields = yields;
        row.color  = color;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic idx, input logic [15:0] val);
        plan_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    task automatic send_request(input logic [1:0] f, input logic [2:0] m,
                                input logic [31:0] now);
        s_valid  <= 1'b1;
        s_func   <= f;
        s_mode   <= m;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (tx_idles && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat (gap_len()) @(negedge aclk);
        end
    endtask

    // stop sending and wait until every color has come out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_LED_ENABLE) begin
            led_on = val[0];
        end else begin
            interval_ms = val;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : track_flow
        rgb_t c;
        bit   y;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                y = next_color(s_func, s_mode, s_now_ms, c);
                if (cur_typed) begin
                    y = cur_yields;
                    c = cur_color;
                end
                if (y) begin
                    pending_colors.push_back(c);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_colors.size() == 0) begin
                    $error("color %0d %0d %0d with none pending", m_red, m_green, m_blue);
                    errors++;
                end else begin
                    c = pending_colors.pop_front();
                    if (m_red !== c.red) begin
                        $error("red mismatch: expected %0d, actual %0d", c.red, m_red);
                        errors++;
                    end
                    if (m_green !== c.green) begin
                        $error("green mismatch: expected %0d, actual %0d", c.green, m_green);
                        errors++;
                    end
                    if (m_blue !== c.blue) begin
                        $error("blue mismatch: expected %0d, actual %0d", c.blue, m_blue);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status_led_breathing_pattern test failed");
            $finish;
        end
    end

    // result side
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
            end else if (rx_idles && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int          useful;
        int          round;
        int          pick;
        bit          enabled;
        logic [15:0] iv;
        logic [1:0]  f;
        logic [2:0]  m;
        logic [2:0]  last_mode;
        logic [31:0] now;
        logic [31:0] sim_ms;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_LED_ENABLE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_func       = FUNC_SET_MODE;
        s_mode       = MODE_IDLE;
        s_now_ms     = '0;
        led_on       = 1'b0;
        interval_ms  = TICK_INTERVAL_RST;
        cur_mode     = MODE_IDLE;
        mode_set     = 1'b0;
        breath_phase = 3'd0;
        tick_stamp   = '0;
        errors       = 0;
        quiet_cycles = 0;
        cur_typed    = 1'b0;
        cur_yields   = 1'b0;
        cur_color    = '0;
        tx_idles     = 1'b1;
        rx_idles     = 1'b1;
        hold_rx      = 1'b0;
        useful       = 0;
        round        = 0;
        last_mode    = MODE_IDLE;
        sim_ms       = '0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // disabled after reset
        directed_plan.push_back(known_row(FUNC_TICK, MODE_IDLE, 32'd500, 1'b0, '0));
        directed_plan.push_back(known_row(FUNC_OFF, MODE_IDLE, 32'd0, 1'b0, '0));
        directed_plan.push_back(known_row(FUNC_RSVD, MODE_SPARE, 32'hFFFF_FFFF, 1'b0, '0));
        directed_plan.push_back(cfg_row(CFG_LED_ENABLE, 16'd1));
        // tick with no mode set yet, then interval boundary
        directed_plan.push_back(req_row(FUNC_TICK, MODE_LOST, 32'd120));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'd239));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'd240));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_IDLE, 32'd0, 1'b1, '0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_IDLE, 32'd0, 1'b0, '0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_SPARE, 32'd0, 1'b1, '0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_SPARE, 32'd0, 1'b0, '0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_LEADER, 32'd0, 1'b1,
                                          '{8'd1, 8'd0, 8'd0}));
        directed_plan.push_back(req_row(FUNC_SET_MODE, MODE_MEMBER, 32'd0));
        directed_plan.push_back(req_row(FUNC_SET_MODE, MODE_RELAY, 32'd0));
        directed_plan.push_back(req_row(FUNC_SET_MODE, MODE_CHILD, 32'd0));
        directed_plan.push_back(req_row(FUNC_SET_MODE, MODE_JOINING, 32'd0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_LOST, 32'd0, 1'b1,
                                          '{8'd2, 8'd0, 8'd0}));
        // time wraps past 2^32
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'hFFFF_FFFF));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'h0000_0077));
        directed_plan.push_back(known_row(FUNC_OFF, MODE_LOST, 32'd0, 1'b1, '0));
        directed_plan.push_back(known_row(FUNC_RSVD, MODE_LEADER, 32'd0, 1'b0, '0));
        // mode change and off while disabled
        directed_plan.push_back(cfg_row(CFG_LED_ENABLE, 16'd0));
        directed_plan.push_back(known_row(FUNC_SET_MODE, MODE_JOINING, 32'd0, 1'b0, '0));
        directed_plan.push_back(known_row(FUNC_OFF, MODE_IDLE, 32'd0, 1'b0, '0));
        directed_plan.push_back(cfg_row(CFG_LED_ENABLE, 16'd1));
        // zero interval, then widest interval
        directed_plan.push_back(cfg_row(CFG_TICK_INTERVAL, 16'd0));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'h0000_0077));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'h0000_0077));
        directed_plan.push_back(cfg_row(CFG_TICK_INTERVAL, 16'hFFFF));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'h0001_0075));
        directed_plan.push_back(req_row(FUNC_TICK, MODE_IDLE, 32'h0001_0076));

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                settle();
                write_cfg(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
            end else begin
                cur_typed  = directed_plan[i].typed;
                cur_yields = directed_plan[i].yields;
                cur_color  = directed_plan[i].color;
                send_request(directed_plan[i].func, directed_plan[i].mode,
                             directed_plan[i].now);
            end
        end
        cur_typed = 1'b0;
        sim_ms    = 32'h0001_0076;

        while (useful < RANDOM_ITEMS) begin
            settle();
            enabled = (round % 6 != 5);
            case ($urandom_range(0, 9))
                0:       iv = 16'd0;
                1:       iv = 16'd1;
                2:       iv = 16'hFFFF;
                3:       iv = TICK_INTERVAL_RST;
                default: iv = 16'($urandom_range(1, 400));
            endcase
            tx_idles = ($urandom_range(0, 3) != 0);
            rx_idles = ($urandom_range(0, 3) != 0);
            // long receiver hold with back-to-back ticks on the request side
            if (round == 2) begin
                iv       = 16'd0;
                tx_idles = 1'b0;
            end
            write_cfg(CFG_LED_ENABLE, {15'd0, enabled});
            write_cfg(CFG_TICK_INTERVAL, iv);
            if ($urandom_range(0, 3) == 0) begin
                sim_ms = $urandom();
            end
            if (round == 2) begin
                hold_rx = 1'b1;
            end
            repeat (enabled ? 100 : 30) begin
                pick = $urandom_range(0, 99);
                m    = 3'($urandom_range(0, 7));
                now  = $urandom();
                if (round == 2 || pick < 55) begin
                    f    = FUNC_TICK;
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        sim_ms = sim_ms + $urandom_range(0, 2 * {16'd0, iv} + 2);
                        now    = sim_ms;
                    end else if (pick < 80) begin
                        sim_ms = sim_ms + {16'd0, iv};
                        now    = sim_ms;
                    end else if (pick < 90) begin
                        sim_ms = sim_ms + {16'd0, iv} - 32'd1;
                        now    = sim_ms;
                    end
                end else if (pick < 75) begin
                    f = FUNC_SET_MODE;
                    if ($urandom_range(0, 2) == 0) begin
                        m = last_mode;
                    end
                    last_mode = m;
                end else if (pick < 92) begin
                    f = FUNC_OFF;
                end else begin
                    f = FUNC_RSVD;
                end
                send_request(f, m, now);
                useful++;
            end
            round++;
        end

        settle();
        if (errors == 0) begin
            $display("status_led_breathing_pattern test passed");
        end else begin
            $display("status_led_breathing_pattern test failed");
        end
        $finish;
    end

endmodule
